[hw/rtl/lmd_pkg.sv]
// Shared types and constants for the LED matrix driver bus target.
package lmd_pkg;

	localparam int DefRamDepth = 16;
	localparam int PtrWidth    = 8;

	typedef enum logic [1:0] {
		EV_BYTE   = 2'd0,
		EV_READ   = 2'd1,
		EV_FINISH = 2'd2,
		EV_NONE   = 2'd3
	} event_t;

	localparam logic [7:0] CMD_SYS    = 8'h20;
	localparam logic [7:0] CMD_DISP   = 8'h80;
	localparam logic [7:0] CMD_ROWINT = 8'hA0;
	localparam logic [7:0] CMD_DIM    = 8'hE0;

	localparam logic [7:0] MASK_SYS    = 8'hFE;
	localparam logic [7:0] MASK_DISP   = 8'hF8;
	localparam logic [7:0] MASK_ROWINT = 8'hFC;
	localparam logic [7:0] MASK_DIM    = 8'hF0;

endpackage

[hw/rtl/led_matrix_driver_i2c_target.sv]
// Top level: bus event decoder, display RAM and setup registers of the LED matrix driver.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, cmd, rx_byte      | input
//  out     | out_valid, out_stall, read_valid,     | output
//          | read_data, oscillator_on, display_on, |
//          | blink_mode, row_int_mode, dim_level   |
//
// One event per cycle while no held result stalls. An event is registered on accept and
// decoded in the following cycle; its result is registered once no held result blocks it.
// Reset clears the display RAM, pointer, mode and setup registers at once; no clearing pass.
// A held result stalls the input only when the input register is also full.
module led_matrix_driver_i2c_target
	import lmd_pkg::*;
#(
	parameter int RAM_DEPTH = DefRamDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic       oscillator_on,
	output logic       display_on,
	output logic [1:0] blink_mode,
	output logic [1:0] row_int_mode,
	output logic [3:0] dim_level
);

	localparam int AddrWidth = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam logic [PtrWidth:0] DepthExt = (PtrWidth + 1)'(RAM_DEPTH);

	// input register
	logic                valid_s1;
	event_t              cmd_s1;
	logic [7:0]          byte_s1;

	// block state
	logic [7:0]          ram_q [RAM_DEPTH];
	logic [PtrWidth-1:0] ptr_q;
	logic                wmode_q;
	logic                osc_q;
	logic [2:0]          disp_q;
	logic [1:0]          rowint_q;
	logic [3:0]          dim_q;

	logic                advance;
	logic                in_disp;
	logic [AddrWidth-1:0] ram_idx;
	logic [PtrWidth:0]   ptr_inc;
	logic [PtrWidth-1:0] ptr_adv;
	logic                byte_is_addr;

	logic [PtrWidth-1:0] ptr_d;
	logic                wmode_d;
	logic                osc_d;
	logic [2:0]          disp_d;
	logic [1:0]          rowint_d;
	logic [3:0]          dim_d;
	logic                ram_we;
	logic                rvalid_d;
	logic [7:0]          rdata_d;

	assign advance  = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;

	assign in_disp      = {1'b0, ptr_q} < DepthExt;
	assign ram_idx      = ptr_q[AddrWidth-1:0];
	assign ptr_inc      = {1'b0, ptr_q} + 1'b1;
	// display addresses wrap at the RAM end, others roll over modulo 256
	assign ptr_adv      = (in_disp && ptr_inc >= DepthExt) ? '0 : ptr_inc[PtrWidth-1:0];
	assign byte_is_addr = {1'b0, byte_s1} < DepthExt;

	always_comb begin
		ptr_d    = ptr_q;
		wmode_d  = wmode_q;
		osc_d    = osc_q;
		disp_d   = disp_q;
		rowint_d = rowint_q;
		dim_d    = dim_q;
		ram_we   = 1'b0;
		rvalid_d = 1'b0;
		rdata_d  = '0;
		case (cmd_s1)
			EV_BYTE: begin
				if (wmode_q) begin
					ram_we = in_disp;
					ptr_d  = ptr_adv;
				end else if (byte_is_addr) begin
					ptr_d   = byte_s1;
					wmode_d = 1'b1;
				end else if ((byte_s1 & MASK_SYS) == CMD_SYS) begin
					ptr_d = CMD_SYS;
					osc_d = byte_s1[0];
				end else if ((byte_s1 & MASK_DISP) == CMD_DISP) begin
					ptr_d  = CMD_DISP;
					disp_d = byte_s1[2:0];
				end else if ((byte_s1 & MASK_ROWINT) == CMD_ROWINT) begin
					ptr_d    = CMD_ROWINT;
					rowint_d = byte_s1[1:0];
				end else if ((byte_s1 & MASK_DIM) == CMD_DIM) begin
					ptr_d = CMD_DIM;
					dim_d = byte_s1[3:0];
				end else begin
					ptr_d = byte_s1;
				end
			end
			EV_READ: begin
				rvalid_d = 1'b1;
				rdata_d  = in_disp ? ram_q[ram_idx] : '0;
				ptr_d    = ptr_adv;
			end
			EV_FINISH: begin
				wmode_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= event_t'(cmd);
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RAM_DEPTH; i++) begin
				ram_q[i] <= '0;
			end
		end else if (advance && ram_we) begin
			ram_q[ram_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			wmode_q       <= 1'b0;
			osc_q         <= 1'b0;
			disp_q        <= '0;
			rowint_q      <= '0;
			dim_q         <= '0;
			out_valid     <= 1'b0;
			read_valid    <= 1'b0;
			read_data     <= '0;
			oscillator_on <= 1'b0;
			display_on    <= 1'b0;
			blink_mode    <= '0;
			row_int_mode  <= '0;
			dim_level     <= '0;
		end else begin
			if (advance) begin
				ptr_q         <= ptr_d;
				wmode_q       <= wmode_d;
				osc_q         <= osc_d;
				disp_q        <= disp_d;
				rowint_q      <= rowint_d;
				dim_q         <= dim_d;
				out_valid     <= 1'b1;
				read_valid    <= rvalid_d;
				read_data     <= rdata_d;
				oscillator_on <= osc_d;
				display_on    <= disp_d[0];
				blink_mode    <= disp_d[2:1];
				row_int_mode  <= rowint_d;
				dim_level     <= dim_d;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/lmd_checker.sv]
// Port-level checks for the LED matrix driver bus target, bound to the top level.
module lmd_checker
	import lmd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] cmd,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic       read_valid,
	input logic [7:0] read_data,
	input logic       oscillator_on,
	input logic       display_on,
	input logic [1:0] blink_mode,
	input logic [1:0] row_int_mode,
	input logic [3:0] dim_level
);

	// a non-read result never carries data
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_data == 8'h00)
		else $error("read_data nonzero on a non-read result");

	// input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no held result");

	// setup outputs move only together with a new result
	a_setup_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable({oscillator_on, display_on, blink_mode, row_int_mode, dim_level})
		|-> out_valid)
		else $error("setup outputs changed without a result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_valid) && $stable(read_data))
		else $error("held result changed");

	// a stalled input transfer keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(cmd) && $stable(rx_byte))
		else $error("stalled input changed");

endmodule

bind led_matrix_driver_i2c_target lmd_checker u_lmd_checker (.*);

[verif/led_matrix_driver_i2c_target_tb.sv]
// Testbench for the LED matrix driver bus target: directed and random bus events checked against a predictor.
module led_matrix_driver_i2c_target_tb;
	import lmd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RamDepth = DefRamDepth;

	typedef struct packed {
		logic       rd_valid;
		logic [7:0] rd_data;
		logic       osc_on;
		logic       disp_on;
		logic [1:0] blink;
		logic [1:0] row_int;
		logic [3:0] dim;
	} panel_status_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic       read_valid;
	logic [7:0] read_data;
	logic       oscillator_on;
	logic       display_on;
	logic [1:0] blink_mode;
	logic [1:0] row_int_mode;
	logic [3:0] dim_level;

	led_matrix_driver_i2c_target u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_valid    (read_valid),
		.read_data     (read_data),
		.oscillator_on (oscillator_on),
		.display_on    (display_on),
		.blink_mode    (blink_mode),
		.row_int_mode  (row_int_mode),
		.dim_level     (dim_level)
	);

	// predictor state
	logic [7:0] ram_m [RamDepth];
	logic [7:0] ptr_m;
	logic       wmode_m;
	logic       osc_m;
	logic [2:0] disp_m;
	logic [1:0] rowint_m;
	logic [3:0] dim_m;

	panel_status_t pending_status[$];
	int unsigned   mismatches;
	int unsigned   items_sent;
	int unsigned   src_idle_pct;
	int unsigned   rcv_stall_pct;
	int unsigned   hold_req;
	int unsigned   hold_left;

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// display addresses wrap inside the RAM, everything else wraps at 256
	function automatic void bump_pointer();
		if (ptr_m < RamDepth)
			ptr_m = (ptr_m == RamDepth - 1) ? 8'd0 : ptr_m + 8'd1;
		else
			ptr_m = ptr_m + 8'd1;
	endfunction

	function automatic panel_status_t apply_bus_event(event_t ev, logic [7:0] b);
		panel_status_t r;
		r = '0;
		case (ev)
			EV_BYTE: begin
				if (wmode_m) begin
					if (ptr_m < RamDepth)
						ram_m[ptr_m] = b;
					bump_pointer();
				end else if (b < RamDepth) begin
					ptr_m = b;
					wmode_m = 1'b1;
				end else if ((b & MASK_SYS) == CMD_SYS) begin
					ptr_m = CMD_SYS;
					osc_m = b[0];
				end else if ((b & MASK_DISP) == CMD_DISP) begin
					ptr_m = CMD_DISP;
					disp_m = b[2:0];
				end else if ((b & MASK_ROWINT) == CMD_ROWINT) begin
					ptr_m = CMD_ROWINT;
					rowint_m = b[1:0];
				end else if ((b & MASK_DIM) == CMD_DIM) begin
					ptr_m = CMD_DIM;
					dim_m = b[3:0];
				end else begin
					ptr_m = b;
				end
			end
			EV_READ: begin
				r.rd_valid = 1'b1;
				r.rd_data = (ptr_m < RamDepth) ? ram_m[ptr_m] : 8'd0;
				bump_pointer();
			end
			EV_FINISH: wmode_m = 1'b0;
			default: ;
		endcase
		r.osc_on = osc_m;
		r.disp_on = disp_m[0];
		r.blink = disp_m[2:1];
		r.row_int = rowint_m;
		r.dim = dim_m;
		return r;
	endfunction

	task automatic send_event(input event_t ev, input logic [7:0] data);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = ev;
		rx_byte = data;
		do @(posedge clk); while (in_stall);
		pending_status.push_back(apply_bus_event(ev, data));
		if (ev != EV_NONE)
			items_sent++;
	endtask

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h at %0t", fname, want, got,
					$realtime);
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		panel_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer at %0t", $realtime);
			end else begin
				want = pending_status.pop_front();
				check_field("read_valid", want.rd_valid, read_valid);
				check_field("read_data", want.rd_data, read_data);
				check_field("oscillator_on", want.osc_on, oscillator_on);
				check_field("display_on", want.disp_on, display_on);
				check_field("blink_mode", want.blink, blink_mode);
				check_field("row_int_mode", want.row_int, row_int_mode);
				check_field("dim_level", want.dim, dim_level);
			end
		end
	end

	task automatic test_directed_cases();
		send_event(EV_READ, 8'h00);       // RAM right after reset
		send_event(EV_BYTE, 8'h00);
		send_event(EV_BYTE, 8'hFF);
		send_event(EV_BYTE, 8'h5A);
		send_event(EV_FINISH, 8'hFF);
		send_event(EV_BYTE, 8'h0F);       // top display address, write wraps to 0
		send_event(EV_BYTE, 8'hA5);
		send_event(EV_BYTE, 8'h00);
		send_event(EV_FINISH, 8'h00);
		send_event(EV_BYTE, 8'h0F);
		send_event(EV_FINISH, 8'h00);
		send_event(EV_READ, 8'h00);       // read wraps from 0x0F to 0x00
		send_event(EV_READ, 8'hFF);
		send_event(EV_BYTE, 8'h20);
		send_event(EV_BYTE, 8'h21);
		send_event(EV_BYTE, 8'h80);
		send_event(EV_BYTE, 8'h87);
		send_event(EV_BYTE, 8'hA3);
		send_event(EV_BYTE, 8'hE0);
		send_event(EV_BYTE, 8'hEF);
		send_event(EV_BYTE, 8'h40);       // key data area reads as zero
		send_event(EV_READ, 8'h00);
		send_event(EV_BYTE, 8'hFF);
		send_event(EV_READ, 8'h00);       // pointer wraps at 256
		send_event(EV_NONE, 8'hFF);
	endtask

	task automatic send_write_burst(input int unsigned len);
		send_event(EV_BYTE, 8'($urandom_range(0, RamDepth - 1)));
		repeat (len) send_event(EV_BYTE, 8'($urandom));
		if ($urandom_range(0, 9) != 0)
			send_event(EV_FINISH, 8'($urandom));
	endtask

	task automatic send_read_burst(input logic [7:0] start, input int unsigned len);
		send_event(EV_BYTE, start);
		send_event(EV_FINISH, 8'($urandom));
		repeat (len) send_event(EV_READ, 8'($urandom));
	endtask

	task automatic test_random_traffic(input int unsigned n);
		int unsigned start;
		logic [7:0]  b;
		start = items_sent;
		while (items_sent - start < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_write_burst($urandom_range(1, 20));
				4, 5: send_read_burst(8'($urandom_range(0, RamDepth - 1)),
					$urandom_range(1, 20));
				6: begin
					case ($urandom_range(0, 3))
						0: b = CMD_SYS | 8'($urandom_range(0, 1));
						1: b = CMD_DISP | 8'($urandom_range(0, 7));
						2: b = CMD_ROWINT | 8'($urandom_range(0, 3));
						default: b = CMD_DIM | 8'($urandom_range(0, 15));
					endcase
					send_event(EV_FINISH, 8'($urandom));
					send_event(EV_BYTE, b);
				end
				7: send_read_burst(8'($urandom_range(RamDepth, 255)), $urandom_range(1, 8));
				default: begin
					repeat ($urandom_range(1, 5))
						send_event(event_t'($urandom_range(0, 3)), 8'($urandom));
				end
			endcase
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		hold_req = 300;
		repeat (40) send_event(event_t'($urandom_range(0, 2)), 8'($urandom));
	endtask

	initial begin
		int unsigned drain_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = EV_NONE;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		mismatches = 0;
		items_sent = 0;
		hold_req = 0;
		hold_left = 0;
		src_idle_pct = 10;
		rcv_stall_pct = 60;
		foreach (ram_m[i]) ram_m[i] = 8'h00;
		ptr_m = 8'h00;
		wmode_m = 1'b0;
		osc_m = 1'b0;
		disp_m = 3'd0;
		rowint_m = 2'd0;
		dim_m = 4'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_random_traffic(560);
		src_idle_pct = 60;
		rcv_stall_pct = 10;
		test_backpressure();
		test_random_traffic(560);
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		test_random_traffic(520);

		@(negedge clk);
		in_valid = 1'b0;
		drain_cycles = 0;
		while (pending_status.size() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (4) @(posedge clk);
		if (pending_status.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", pending_status.size());
		end
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
hw/rtl/lmd_pkg.sv
hw/rtl/led_matrix_driver_i2c_target.sv
hw/rtl/lmd_checker.sv
verif/led_matrix_driver_i2c_target_tb.sv
